>>> design/lsi_pkg.sv
package lsi_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int PIXEL_BITS = 10;
	localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
	localparam int ROWS       = 7;
	localparam int LANE_BITS  = 16;
	localparam int HSHIFT     = PIXEL_BITS - 8;
	localparam int UNI_SHIFT  = 14 - PIXEL_BITS;
	localparam int BI_SHIFT   = 15 - PIXEL_BITS;
	localparam int PIX_MAX    = (1 << PIXEL_BITS) - 1;

	// register indexes of the configuration port
	localparam logic [2:0] REG_FRAC_X  = 3'd0;
	localparam logic [2:0] REG_FRAC_Y  = 3'd1;
	localparam logic [2:0] REG_WIDTH   = 3'd2;
	localparam logic [2:0] REG_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_MODE    = 3'd4;

	localparam logic [1:0] MODE_UNI    = 2'd0;
	localparam logic [1:0] MODE_BI_INT = 2'd1;
	localparam logic [1:0] MODE_BI_ADD = 2'd2;

	typedef logic [7:0][7:0] tap_row_t;
	typedef logic [ROWS-1:0][LANE_BITS-1:0] line_word_t;

	function automatic tap_row_t taps(input logic [3:0] f);
		tap_row_t t;
		case (f)
			4'd0:    t = {8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd64, 8'sd0, 8'sd0, 8'sd0};
			4'd1:    t = {8'sd0, 8'sd1, -8'sd2, 8'sd4, 8'sd63, -8'sd3, 8'sd1, 8'sd0};
			4'd2:    t = {8'sd0, 8'sd1, -8'sd3, 8'sd8, 8'sd62, -8'sd5, 8'sd2, -8'sd1};
			4'd3:    t = {8'sd0, 8'sd1, -8'sd4, 8'sd13, 8'sd60, -8'sd8, 8'sd3, -8'sd1};
			4'd4:    t = {8'sd0, 8'sd1, -8'sd5, 8'sd17, 8'sd58, -8'sd10, 8'sd4, -8'sd1};
			4'd5:    t = {-8'sd1, 8'sd3, -8'sd8, 8'sd26, 8'sd52, -8'sd11, 8'sd4, -8'sd1};
			4'd6:    t = {-8'sd1, 8'sd4, -8'sd10, 8'sd31, 8'sd47, -8'sd9, 8'sd3, -8'sd1};
			4'd7:    t = {-8'sd1, 8'sd4, -8'sd10, 8'sd34, 8'sd45, -8'sd11, 8'sd4, -8'sd1};
			4'd8:    t = {-8'sd1, 8'sd4, -8'sd11, 8'sd40, 8'sd40, -8'sd11, 8'sd4, -8'sd1};
			4'd9:    t = {-8'sd1, 8'sd4, -8'sd11, 8'sd45, 8'sd34, -8'sd10, 8'sd4, -8'sd1};
			4'd10:   t = {-8'sd1, 8'sd3, -8'sd9, 8'sd47, 8'sd31, -8'sd10, 8'sd4, -8'sd1};
			4'd11:   t = {-8'sd1, 8'sd4, -8'sd11, 8'sd52, 8'sd26, -8'sd8, 8'sd3, -8'sd1};
			4'd12:   t = {-8'sd1, 8'sd4, -8'sd10, 8'sd58, 8'sd17, -8'sd5, 8'sd1, 8'sd0};
			4'd13:   t = {-8'sd1, 8'sd3, -8'sd8, 8'sd60, 8'sd13, -8'sd4, 8'sd1, 8'sd0};
			4'd14:   t = {-8'sd1, 8'sd2, -8'sd5, 8'sd62, 8'sd8, -8'sd3, 8'sd1, 8'sd0};
			4'd15:   t = {8'sd0, 8'sd1, -8'sd3, 8'sd63, 8'sd4, -8'sd2, 8'sd1, 8'sd0};
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

>>> design/luma_subpel_interpolation_core.sv
// Luma 8-tap sub-pel interpolator. Pixels of the (width+7) x (height+7) window come in raster
// order, one at a time; an item in the first seven columns of a row passes accept and the
// horizontal filter, one whose column goes to the line store adds vertical filter and
// write-back, and one that yields a sample adds the result step. The line store is
// read-modify-write: one 112-bit word per column holding the seven stored rows. A finished
// sample waits in the output register while the next item is taken; a sample that finds the
// register still held stalls the input until the receiver takes the old one.
// block_done marks the last sample.
module luma_subpel_interpolation_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [9:0]          ref_pixel,
	input  logic signed [15:0]  other_pred,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  pred_sample,
	output logic                block_done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_H    = 2'd1;
	localparam logic [1:0] ST_V    = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam int AW = lsi_pkg::ADDR_BITS;

	logic [3:0] frac_x_q, frac_y_q;
	logic [7:0] width_q, height_q;
	logic [1:0] mode_q;
	logic [1:0] state_q;

	logic [7:0] col_q, row_q;
	logic [2:0] slot_q;
	logic [6:0][lsi_pkg::PIXEL_BITS-1:0] win_q;

	logic [7:0][lsi_pkg::PIXEL_BITS-1:0] hwin_s1;
	logic [AW-1:0]  x_s1;
	logic [2:0]     slot_s1;
	logic           emit_s1, wr_s1, done_s1;
	logic signed [15:0] other_s1;

	lsi_pkg::line_word_t line_mem [lsi_pkg::MAX_WIDTH];
	lsi_pkg::line_word_t rd_q, line_s2;
	logic signed [15:0] hval_s2;
	logic signed [18:0] v_s3;

	logic                out_valid_q, done_q;
	logic signed [15:0]  out_q;

	// saturated geometry and row/column ends
	logic [7:0] w_sat, h_sat;
	logic       last_col, last_row;
	logic [7:0] col_m7;
	logic [lsi_pkg::PIXEL_BITS-1:0] pix;

	always_comb begin
		w_sat = (width_q == 8'd0) ? 8'd1 :
			((width_q > 8'(lsi_pkg::MAX_WIDTH)) ? 8'(lsi_pkg::MAX_WIDTH) : width_q);
		h_sat = (height_q == 8'd0) ? 8'd1 : ((height_q > 8'd128) ? 8'd128 : height_q);
		last_col = {1'b0, col_q} >= ({1'b0, w_sat} + 9'd6);
		last_row = {1'b0, row_q} >= ({1'b0, h_sat} + 9'd6);
		col_m7 = col_q - 8'd7;
		pix = ref_pixel[lsi_pkg::PIXEL_BITS-1:0];
	end

	assign in_ready = (state_q == ST_IDLE);
	logic accept;
	assign accept = in_valid && in_ready;

	// the finished sample moves to the output register once that is free
	logic load_out;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// horizontal filter
	lsi_pkg::tap_row_t th, tv;
	logic signed [19:0] hsum;
	logic signed [19:0] hsh;
	always_comb begin
		th = lsi_pkg::taps(frac_x_q);
		hsum = '0;
		for (int k = 0; k < 8; k++) begin
			hsum = hsum + 20'($signed(th[k]) * $signed({1'b0, hwin_s1[k]}));
		end
		hsh = hsum >>> lsi_pkg::HSHIFT;
	end

	// vertical filter, stored row of tap k sits in lane (slot + k) mod 7
	logic signed [24:0] vsum;
	logic [3:0]         lane;
	always_comb begin
		tv = lsi_pkg::taps(frac_y_q);
		vsum = 25'($signed(tv[7]) * hval_s2);
		lane = '0;
		for (int k = 0; k < 7; k++) begin
			lane = {1'b0, slot_s1} + 4'(k);
			if (lane >= 4'd7)
				lane = lane - 4'd7;
			vsum = vsum + 25'($signed(tv[k]) * $signed(line_s2[lane[2:0]]));
		end
	end

	lsi_pkg::line_word_t wr_word;
	always_comb begin
		wr_word = line_s2;
		wr_word[slot_s1] = hval_s2;
	end

	// final rounding per mode (MODE_BI_INT passes the vertical result unrounded)
	logic signed [21:0] rsum, rsh;
	logic signed [15:0] res;
	always_comb begin
		if (mode_q == lsi_pkg::MODE_BI_ADD) begin
			rsum = 22'(v_s3) + 22'(other_s1) + 22'(1 << (lsi_pkg::BI_SHIFT - 1));
			rsh = rsum >>> lsi_pkg::BI_SHIFT;
		end else begin
			rsum = 22'(v_s3) + 22'(1 << (lsi_pkg::UNI_SHIFT - 1));
			rsh = rsum >>> lsi_pkg::UNI_SHIFT;
		end
		if (mode_q == lsi_pkg::MODE_BI_INT)
			res = v_s3[15:0];
		else if (rsh < 0)
			res = '0;
		else if (rsh > 22'(lsi_pkg::PIX_MAX))
			res = 16'(lsi_pkg::PIX_MAX);
		else
			res = rsh[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			width_q <= 8'd8;
			height_q <= 8'd8;
			mode_q <= lsi_pkg::MODE_UNI;
		end else if (cfg_write) begin
			case (cfg_index)
				lsi_pkg::REG_FRAC_X: frac_x_q <= cfg_data[3:0];
				lsi_pkg::REG_FRAC_Y: frac_y_q <= cfg_data[3:0];
				lsi_pkg::REG_WIDTH:  width_q <= cfg_data;
				lsi_pkg::REG_HEIGHT: height_q <= cfg_data;
				lsi_pkg::REG_MODE:   mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			row_q <= '0;
			slot_q <= '0;
			win_q <= '0;
			emit_s1 <= 1'b0;
			wr_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						emit_s1 <= (col_q >= 8'd7) && (row_q >= 8'd7);
						wr_s1 <= (col_q >= 8'd7);
						win_q <= {pix, win_q[6:1]};
						if (last_col) begin
							col_q <= '0;
							if (last_row) begin
								row_q <= '0;
								slot_q <= '0;
							end else begin
								row_q <= row_q + 8'd1;
								slot_q <= (slot_q == 3'd6) ? 3'd0 : slot_q + 3'd1;
							end
						end else begin
							col_q <= col_q + 8'd1;
						end
						state_q <= ST_H;
					end
				end
				ST_H: state_q <= wr_s1 ? ST_V : ST_IDLE;
				ST_V: state_q <= emit_s1 ? ST_OUT : ST_IDLE;
				ST_OUT: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			hwin_s1 <= {pix, win_q};
			x_s1 <= col_m7[AW-1:0];
			slot_s1 <= slot_q;
			other_s1 <= other_pred;
			done_s1 <= last_col && last_row;
		end
		if (state_q == ST_H) begin
			line_s2 <= rd_q;
			hval_s2 <= hsh[15:0];
		end
		if (state_q == ST_V)
			v_s3 <= 19'(vsum >>> 6);
		if (load_out) begin
			out_q <= res;
			done_q <= done_s1;
		end
	end

	// line store: one word per column, read at accept, written back after the vertical pass
	always_ff @(posedge clk) begin
		if (accept)
			rd_q <= line_mem[col_m7[AW-1:0]];
		if (state_q == ST_V && wr_s1)
			line_mem[x_s1] <= wr_word;
	end

	assign out_valid = out_valid_q;
	assign pred_sample = out_q;
	assign block_done = done_q;

endmodule
